>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared request codes and control/status types for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int KEY_W    = 32;
    localparam int ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_BACK   = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    // controller -> datapath
    typedef struct packed {
        logic take;      // request accepted this cycle
        logic pop_done;  // ring read data is valid, load the result
    } deq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic rd_req;    // offered request is a pop on a non-empty queue
        logic out_busy;  // result register full and not taken this cycle
    } deq_stat_t;

endpackage

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: accepts requests and waits out the ring read of a pop.
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  deq_stat_t stat,
    output deq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } deq_state_t;

    deq_state_t state_reg;
    deq_state_t state_next;
    logic       take;

    assign s_tready = (state_reg == ST_IDLE) && !stat.out_busy;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && stat.rd_req)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.take     = take;
    assign cmd.pop_done = (state_reg == ST_READ);

endmodule

>>> rtl/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Front index, count, ring addressing, ring RAM and the result register.
// ----------------------------------------------------------------------------
module deq_dpath
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ACTION_W-1:0] action,
    input  logic [KEY_W-1:0]    push_key,
    input  deq_cmd_t            cmd,
    output deq_stat_t           stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [KEY_W-1:0]    popped_key,
    output logic                done_ok,
    output logic [CW-1:0]       entry_count
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_I  = AW'(DEPTH - 1);

    logic [AW-1:0]    front_reg, front_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             out_valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic             ok_reg;
    logic [CW-1:0]    cnt_out_reg;

    logic             empty, full, ok;
    logic             is_pop;
    logic [AW-1:0]    back_free, back_last, front_dec, front_inc;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [KEY_W-1:0] rd_data;
    action_t          act;

    // position front + offset, offset no larger than DEPTH
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(offset);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign act       = action_t'(action);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_C);
    assign back_free = ring_pos(front_reg, count_reg);
    assign back_last = ring_pos(front_reg, count_reg - CW'(1));
    assign front_dec = (front_reg == '0) ? LAST_I : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_I) ? '0 : front_reg + AW'(1);
    assign is_pop    = (act == ACT_POP_BACK) || (act == ACT_POP_FRONT);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        ok         = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = back_free;
        rd_addr    = front_reg;
        case (act)
            ACT_PUSH_BACK:
            begin
                if (!full)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            ACT_PUSH_FRONT:
            begin
                wr_addr = front_dec;
                if (!full)
                begin
                    wr_en      = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                    ok         = 1'b1;
                end
            end
            ACT_POP_BACK:
            begin
                rd_addr = back_last;
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    count_next = count_reg - CW'(1);
                    ok         = 1'b1;
                end
            end
            ACT_POP_FRONT:
            begin
                if (!empty)
                begin
                    rd_en      = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                    ok         = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
                ok         = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    deq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.take && wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_key),
        .rd_en   (cmd.take && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
            if ((cmd.take && !(is_pop && !empty)) || cmd.pop_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; pops load it once the ring read returns
    always_ff @(posedge clk)
    begin
        if (cmd.pop_done)
        begin
            key_reg     <= rd_data;
            ok_reg      <= 1'b1;
            cnt_out_reg <= count_reg;
        end
        else if (cmd.take)
        begin
            key_reg     <= '0;
            ok_reg      <= ok;
            cnt_out_reg <= count_next;
        end
    end

    assign stat.rd_req   = is_pop && !empty;
    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign popped_key  = key_reg;
    assign done_ok     = ok_reg;
    assign entry_count = cnt_out_reg;

endmodule

>>> rtl/double_ended_queue_top.sv
// Push, clear, unused codes and empty-queue pops give their result the cycle after being taken;
// other pops pass through the registered ring RAM read and then the result register.
// Throughput: one request per cycle unless the result stalls or a pop's ring read is pending.
// Reset (rst_n low, asynchronous): queue empty, front index zero, result register empty.
// Ring RAM contents are not cleared; entries are only read after a push has written them.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit keys over a ring RAM.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [31:0] push_key
    input  logic [2:0]          s_tuser,   // [2:0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] popped_key, [32] done_ok, [32+CW:33] entry_count, zero fill above
    output logic [((KEY_W + 1 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int OW   = ((KEY_W + 1 + CW + 7) / 8) * 8;
    localparam int PADW = OW - (KEY_W + 1 + CW);

    deq_cmd_t         cmd;
    deq_stat_t        stat;
    logic [KEY_W-1:0] popped_key;
    logic             done_ok;
    logic [CW-1:0]    entry_count;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (s_tuser),
        .push_key    (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .popped_key  (popped_key),
        .done_ok     (done_ok),
        .entry_count (entry_count)
    );

    generate
        if (PADW > 0)
        begin : g_pad
            assign m_tdata = {{PADW{1'b0}}, entry_count, done_ok, popped_key};
        end
        else
        begin : g_nopad
            assign m_tdata = {entry_count, done_ok, popped_key};
        end
    endgenerate

endmodule

>>> rtl/deq_chk.sv
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_chk
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [2:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [((KEY_W + 1 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    logic          s_take;
    logic          m_ok;
    logic [CW-1:0] m_count;

    assign s_take  = s_tvalid && s_tready;
    assign m_ok    = m_tdata[KEY_W];
    assign m_count = m_tdata[KEY_W+CW:KEY_W+1];

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_ok |-> m_tdata[KEY_W-1:0] == '0)
        else $error("failed request returned a nonzero key");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && s_tuser == ACT_CLEAR |=> m_tvalid && m_ok && m_count == '0)
        else $error("clear did not report an empty queue");

    a_nonpop_next: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && s_tuser != ACT_POP_BACK && s_tuser != ACT_POP_FRONT
        |=> m_tvalid && m_tdata[KEY_W-1:0] == '0)
        else $error("non-pop request result missing or carrying a key");

endmodule

bind double_ended_queue_top deq_chk #(
    .DEPTH (DEPTH)
) u_deq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
